// File: rtl/core_task_dispatcher_defines.svh
// Assertion macros shared by the dispatcher checker.
`ifndef CORE_TASK_DISPATCHER_DEFINES_SVH
`define CORE_TASK_DISPATCHER_DEFINES_SVH

// Checked only while the block is out of reset.
`define CTD_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, including while reset is held.
`define CTD_ASSERT_ALWAYS(lbl, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ctd_pkg.sv
// Types and constants of the core task dispatcher.
package ctd_pkg;

	localparam int MAX_CORES  = 4;
	localparam int CORE_W     = 2;
	localparam int CNT_W      = 4;
	localparam int EXEC_IN_W  = 24;
	localparam int EXEC_W     = 32;
	localparam int MISS_W     = 16;
	localparam int TIME_W     = 32;
	localparam int ACTIVE_W   = 3;
	localparam int CYC_LEN_W  = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LEN = 3'd5;

	localparam logic [ACTIVE_W-1:0]  ACTIVE_RST    = 3'd4;
	localparam logic [CNT_W-1:0]     LIMIT_RST     = 4'd4;
	localparam logic [CYC_LEN_W-1:0] CYCLE_LEN_RST = 20'd10000;

	typedef enum logic [1:0] {
		OP_START_ROUND = 2'd0,
		OP_ASSIGN      = 2'd1,
		OP_COMPLETE    = 2'd2,
		OP_RESET_CYCLE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic signed [3:0]     core;
		logic [EXEC_IN_W-1:0]  exec_us;
		logic                  missed;
		logic [TIME_W-1:0]     deadline_us;
	} req_t;

	typedef struct packed {
		logic                  granted;
		logic [CORE_W-1:0]     chosen_core;
		logic [TIME_W-1:0]     task_deadline_us;
		logic [EXEC_W-1:0]     core_exec_total_us;
		logic [MISS_W-1:0]     core_miss_total;
		logic [MISS_W-1:0]     all_miss_total;
		logic [TIME_W-1:0]     cycle_start_us;
	} res_t;

	typedef struct packed {
		logic              found;
		logic [CORE_W-1:0] idx;
	} pick_t;

endpackage

// File: rtl/ctd_pick.sv
// Core selection: preferred core if it has room, else the least loaded core.
module ctd_pick #(
	parameter int CORE_CNT = 4
) (
	input  logic [CORE_CNT-1:0][ctd_pkg::CNT_W-1:0]  count,
	input  logic [CORE_CNT-1:0][ctd_pkg::CNT_W-1:0]  limit,
	input  logic [ctd_pkg::ACTIVE_W-1:0]             n_use,
	input  logic signed [3:0]                        pref,
	output ctd_pkg::pick_t                           pick
);

	logic [CORE_CNT-1:0]         room;
	logic                        pref_room;
	logic                        pref_ok;
	logic                        best_found;
	logic [ctd_pkg::CORE_W-1:0]  best_idx;
	logic [ctd_pkg::CNT_W:0]     least;

	always_comb begin
		pref_room  = 1'b0;
		best_found = 1'b0;
		best_idx   = '0;
		least      = 5'd16;
		for (int i = 0; i < CORE_CNT; i++) begin
			room[i] = (count[i] < limit[i]) && (ctd_pkg::ACTIVE_W'(i) < n_use);
			if (pref[2:0] == 3'(i)) begin
				pref_room = room[i];
			end
			if (room[i] && ({1'b0, count[i]} < least)) begin
				best_found = 1'b1;
				best_idx   = ctd_pkg::CORE_W'(i);
				least      = {1'b0, count[i]};
			end
		end
		pref_ok = !pref[3] && (pref[2:0] < n_use) && pref_room;
		if (pref_ok) begin
			pick.found = 1'b1;
			pick.idx   = pref[1:0];
		end else begin
			pick.found = best_found;
			pick.idx   = best_idx;
		end
	end

endmodule

// File: rtl/core_task_dispatcher.sv
// Top level of the core task dispatcher.
//
// Requests enter on in_valid/in_stall with an in_req payload and results
// leave on out_valid/out_stall with an out_res payload; every request gives
// exactly one result. A request is taken into an input register, then its
// core selection and counter updates are worked out combinationally and
// the result is written to the output register. out_valid rises when the
// request moves from the input register into the output register.
// Throughput is one request per cycle while out_stall is low, as the
// per-core counters are updated as each request moves on.
// When the receiver stalls, the result register holds its value and the
// input register drains into it as soon as it frees up; in_stall rises only
// while both registers are full and out_stall is high.
// The configuration port (cfg_wr_en, cfg_index, cfg_data) writes one
// register per cycle; use it only while the block is idle (not enforced).
// Reset clears all counters, the cycle start time and the valid flags of
// both registers, and loads the configuration registers with defaults.
module core_task_dispatcher #(
	parameter int CORE_CNT = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ctd_pkg::req_t                     in_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ctd_pkg::res_t                     out_res,
	input  logic                              cfg_wr_en,
	input  logic [ctd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ctd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [ctd_pkg::ACTIVE_W-1:0]                  active_q;
	logic [CORE_CNT-1:0][ctd_pkg::CNT_W-1:0]       limit_q;
	logic [ctd_pkg::CYC_LEN_W-1:0]                 cycle_len_q;

	logic [CORE_CNT-1:0][ctd_pkg::CNT_W-1:0]       count_q, count_d;
	logic [CORE_CNT-1:0][ctd_pkg::EXEC_W-1:0]      exec_q, exec_d;
	logic [CORE_CNT-1:0][ctd_pkg::MISS_W-1:0]      miss_q, miss_d;
	logic [ctd_pkg::MISS_W-1:0]                    miss_sum_q, miss_sum_d;
	logic [ctd_pkg::TIME_W-1:0]                    origin_q, origin_d;

	logic                                          vld_s1;
	ctd_pkg::req_t                                 req_s1;
	logic                                          out_vld_q;
	ctd_pkg::res_t                                 res_q, res_d;

	logic                                          adv;
	logic [ctd_pkg::ACTIVE_W-1:0]                  n_use;
	ctd_pkg::pick_t                                pick;
	logic                                          grant;
	logic                                          cpl_ok;
	logic [ctd_pkg::CORE_W-1:0]                    sel;
	logic [ctd_pkg::EXEC_W:0]                      exec_sum;
	logic [ctd_pkg::EXEC_W-1:0]                    exec_new;
	logic [ctd_pkg::MISS_W-1:0]                    miss_new;

	assign n_use     = (active_q > ctd_pkg::ACTIVE_W'(CORE_CNT)) ?
		ctd_pkg::ACTIVE_W'(CORE_CNT) : active_q;
	assign adv       = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall  = vld_s1 && !adv;
	assign out_valid = out_vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ctd_pkg::ACTIVE_RST;
			limit_q     <= {CORE_CNT{ctd_pkg::LIMIT_RST}};
			cycle_len_q <= ctd_pkg::CYCLE_LEN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ctd_pkg::REG_ACTIVE: begin
					active_q <= cfg_data[ctd_pkg::ACTIVE_W-1:0];
				end
				ctd_pkg::REG_CYCLE_LEN: begin
					cycle_len_q <= cfg_data;
				end
				default: begin
					for (int i = 0; i < CORE_CNT; i++) begin
						if (cfg_index == ctd_pkg::REG_LIMIT0 + ctd_pkg::CFG_IDX_W'(i)) begin
							limit_q[i] <= cfg_data[ctd_pkg::CNT_W-1:0];
						end
					end
				end
			endcase
		end
	end

	ctd_pick #(
		.CORE_CNT(CORE_CNT)
	) u_pick (
		.count(count_q),
		.limit(limit_q),
		.n_use(n_use),
		.pref (req_s1.core),
		.pick (pick)
	);

	always_comb begin
		grant    = (req_s1.op == ctd_pkg::OP_ASSIGN) && pick.found;
		cpl_ok   = (req_s1.op == ctd_pkg::OP_COMPLETE) && !req_s1.core[3] &&
			(req_s1.core[2:0] < n_use);
		sel      = grant ? pick.idx : req_s1.core[1:0];
		count_d  = count_q;
		exec_d   = exec_q;
		miss_d   = miss_q;
		miss_sum_d = miss_sum_q;
		origin_d = origin_q;
		exec_sum = '0;
		exec_new = '0;
		miss_new = '0;
		res_d    = '0;

		for (int i = 0; i < CORE_CNT; i++) begin
			if (sel == ctd_pkg::CORE_W'(i)) begin
				exec_sum = {1'b0, exec_q[i]} + (ctd_pkg::EXEC_W + 1)'(req_s1.exec_us);
				exec_new = exec_sum[ctd_pkg::EXEC_W] ? '1 : exec_sum[ctd_pkg::EXEC_W-1:0];
				miss_new = (req_s1.missed && (miss_q[i] != '1)) ?
					miss_q[i] + 1'b1 : miss_q[i];
				if (grant) begin
					count_d[i] = count_q[i] + 1'b1;
					res_d.core_exec_total_us = exec_q[i];
					res_d.core_miss_total    = miss_q[i];
				end
				if (cpl_ok) begin
					exec_d[i] = exec_new;
					miss_d[i] = miss_new;
					res_d.core_exec_total_us = exec_new;
					res_d.core_miss_total    = miss_new;
				end
			end
		end

		case (req_s1.op)
			ctd_pkg::OP_START_ROUND: begin
				count_d = '0;
			end
			ctd_pkg::OP_COMPLETE: begin
				if (cpl_ok && req_s1.missed && (miss_sum_q != '1)) begin
					miss_sum_d = miss_sum_q + 1'b1;
				end
			end
			ctd_pkg::OP_RESET_CYCLE: begin
				count_d    = '0;
				exec_d     = '0;
				miss_d     = '0;
				miss_sum_d = '0;
				origin_d   = origin_q + ctd_pkg::TIME_W'(cycle_len_q);
			end
			default: begin
			end
		endcase

		res_d.granted          = grant;
		res_d.chosen_core      = grant ? pick.idx : '0;
		res_d.task_deadline_us = grant ? req_s1.deadline_us : '0;
		res_d.all_miss_total   = miss_sum_d;
		res_d.cycle_start_us   = origin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			exec_q     <= '0;
			miss_q     <= '0;
			miss_sum_q <= '0;
			origin_q   <= '0;
		end else if (adv) begin
			count_q    <= count_d;
			exec_q     <= exec_d;
			miss_q     <= miss_d;
			miss_sum_q <= miss_sum_d;
			origin_q   <= origin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

endmodule

// File: rtl/ctd_checker.sv
// Port-level assertions for the core task dispatcher, bound to the top level.
`include "core_task_dispatcher_defines.svh"

module ctd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input ctd_pkg::res_t out_res
);

	logic out_hold;
	logic drop_clean;
	logic miss_order_ok;

	assign out_hold      = out_valid && out_stall;
	assign drop_clean    = (out_res.chosen_core == '0) && (out_res.task_deadline_us == '0);
	assign miss_order_ok = out_res.core_miss_total <= out_res.all_miss_total;

	`CTD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "busy during reset")

	`CTD_ASSERT(a_out_hold, out_hold |=> out_valid && $stable(out_res), "stalled result changed")

	`CTD_ASSERT(a_stall_cause, in_stall |-> out_hold, "request stalled without a stalled result")

	`CTD_ASSERT(a_drop_zero, out_valid && !out_res.granted |-> drop_clean, "dropped core or deadline")

	`CTD_ASSERT(a_miss_order, out_valid |-> miss_order_ok, "core misses exceed total misses")

endmodule

bind core_task_dispatcher ctd_checker u_ctd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_res  (out_res)
);
